// ===== sv/ggm_pkg.sv =====
// Shared definitions for the Godunov upwind gradient magnitude block.
// Holds the default difference width and the level-sign codes.
// No dependencies.
`default_nettype none

package ggm_pkg;

   // Default width of one signed fixed-point difference.
   localparam int DIFF_WIDTH_DEFAULT = 24;

   // Level-sign codes. Both patterns with the top bit set count as negative.
   typedef enum logic [1:0] {
      SIGN_ZERO    = 2'b00,
      SIGN_POS     = 2'b01,
      SIGN_NEG_TWO = 2'b10,
      SIGN_NEG     = 2'b11
   } level_sign_type;

endpackage : ggm_pkg

`default_nettype wire

// ===== sv/ggm_front.sv =====
// Front end of the gradient magnitude pipeline: upwind part selection,
// squaring, per-axis maximum and the axis sum, in three register stages.
// Depends on ggm_pkg.
`default_nettype none

module ggm_front #(
   parameter int DIFF_WIDTH = ggm_pkg::DIFF_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         enable,
   input  wire logic                         in_valid,
   input  wire logic signed [1:0]            level_sign,
   input  wire logic signed [DIFF_WIDTH-1:0] diff_x_back,
   input  wire logic signed [DIFF_WIDTH-1:0] diff_x_fwd,
   input  wire logic signed [DIFF_WIDTH-1:0] diff_y_back,
   input  wire logic signed [DIFF_WIDTH-1:0] diff_y_fwd,
   output logic                              out_valid,
   output logic [2*DIFF_WIDTH-1:0]           out_sum
);

   localparam int W    = DIFF_WIDTH;
   localparam int SQ_W = 2 * W - 1;

   // Magnitude of the wanted part of a difference, zero when that part is empty.
   // The most negative value maps to 2^(W-1), which still fits in W bits.
   function automatic logic [W-1:0] part_mag(input logic [W-1:0] v, input logic want_neg);
      logic [W-1:0] m;
      begin
         m = '0;
         if (want_neg && v[W-1]) begin
            m = ~v + {{(W-1){1'b0}}, 1'b1};
         end else if (!want_neg && !v[W-1]) begin
            m = v;
         end
         return m;
      end
   endfunction

   logic           active;
   logic           back_neg;
   logic [W-1:0]   mag_xb;
   logic [W-1:0]   mag_xf;
   logic [W-1:0]   mag_yb;
   logic [W-1:0]   mag_yf;
   logic [2*W-1:0] prod_xb;
   logic [2*W-1:0] prod_xf;
   logic [2*W-1:0] prod_yb;
   logic [2*W-1:0] prod_yf;

   logic            sq_valid_ff;
   logic [SQ_W-1:0] sq_xb_ff;
   logic [SQ_W-1:0] sq_xf_ff;
   logic [SQ_W-1:0] sq_yb_ff;
   logic [SQ_W-1:0] sq_yf_ff;
   logic            max_valid_ff;
   logic [SQ_W-1:0] max_x_in;
   logic [SQ_W-1:0] max_y_in;
   logic [SQ_W-1:0] max_x_ff;
   logic [SQ_W-1:0] max_y_ff;
   logic             sum_valid_ff;
   logic [2*W-1:0]   sum_in;
   logic [2*W-1:0]   sum_ff;

   // Decode the level sign: a positive sign takes the negative part of the
   // backward difference, a negative sign takes its positive part.
   always_comb begin
      unique case (ggm_pkg::level_sign_type'(level_sign)) inside
         ggm_pkg::SIGN_ZERO: begin
            active   = 1'b0;
            back_neg = 1'b0;
         end
         ggm_pkg::SIGN_POS: begin
            active   = 1'b1;
            back_neg = 1'b1;
         end
         ggm_pkg::SIGN_NEG, ggm_pkg::SIGN_NEG_TWO: begin
            active   = 1'b1;
            back_neg = 1'b0;
         end
         default: begin
            active   = 1'b0;
            back_neg = 1'b0;
         end
      endcase
   end

   // Select the upwind parts; a zero sign clears all four terms.
   always_comb begin
      mag_xb  = active ? part_mag(diff_x_back, back_neg)  : '0;
      mag_xf  = active ? part_mag(diff_x_fwd,  !back_neg) : '0;
      mag_yb  = active ? part_mag(diff_y_back, back_neg)  : '0;
      mag_yf  = active ? part_mag(diff_y_fwd,  !back_neg) : '0;
      prod_xb = {{W{1'b0}}, mag_xb} * {{W{1'b0}}, mag_xb};
      prod_xf = {{W{1'b0}}, mag_xf} * {{W{1'b0}}, mag_xf};
      prod_yb = {{W{1'b0}}, mag_yb} * {{W{1'b0}}, mag_yb};
      prod_yf = {{W{1'b0}}, mag_yf} * {{W{1'b0}}, mag_yf};
   end

   // Larger square on each axis, then the sum of both axes.
   always_comb begin
      max_x_in = (sq_xb_ff >= sq_xf_ff) ? sq_xb_ff : sq_xf_ff;
      max_y_in = (sq_yb_ff >= sq_yf_ff) ? sq_yb_ff : sq_yf_ff;
      sum_in   = {1'b0, max_x_ff} + {1'b0, max_y_ff};
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         max_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (enable) begin
         sq_valid_ff  <= in_valid;
         max_valid_ff <= sq_valid_ff;
         sum_valid_ff <= max_valid_ff;
      end
   end

   // Data of the three stages.
   always_ff @(posedge clock) begin
      if (enable) begin
         sq_xb_ff <= prod_xb[SQ_W-1:0];
         sq_xf_ff <= prod_xf[SQ_W-1:0];
         sq_yb_ff <= prod_yb[SQ_W-1:0];
         sq_yf_ff <= prod_yf[SQ_W-1:0];
         max_x_ff <= max_x_in;
         max_y_ff <= max_y_in;
         sum_ff   <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_sum   = sum_ff;

endmodule : ggm_front

`default_nettype wire

// ===== sv/ggm_root_cell.sv =====
// One cell of the square-root chain: brings down two radicand bits and
// decides one root bit per enabled clock; the next cell takes its state.
// Depends on ggm_pkg for the default width.
`default_nettype none

module ggm_root_cell #(
   parameter int WIDTH = ggm_pkg::DIFF_WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire logic [2*WIDTH-1:0] in_rad,
   input  wire logic [WIDTH-1:0]   in_rem,
   input  wire logic [WIDTH-1:0]   in_root,
   output logic                    out_valid,
   output logic [2*WIDTH-1:0]      out_rad,
   output logic [WIDTH-1:0]        out_rem,
   output logic [WIDTH-1:0]        out_root
);

   logic [WIDTH+1:0]   partial;
   logic [WIDTH+1:0]   trial;
   logic [WIDTH+1:0]   diff;
   logic               take;
   logic               valid_ff;
   logic [2*WIDTH-1:0] rad_in;
   logic [2*WIDTH-1:0] rad_ff;
   logic [WIDTH-1:0]   rem_in;
   logic [WIDTH-1:0]   rem_ff;
   logic [WIDTH-1:0]   root_in;
   logic [WIDTH-1:0]   root_ff;

   // Restoring step: try 4*root+1 against the remainder with two new bits.
   // Before the step the remainder is below 2^WIDTH and the root below
   // 2^(WIDTH-1), so the dropped top bits are always zero.
   always_comb begin
      partial = {in_rem, in_rad[2*WIDTH-1 -: 2]};
      trial   = {1'b0, in_root[WIDTH-2:0], 2'b01};
      diff    = partial - trial;
      take    = (partial >= trial);
      rem_in  = take ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
      root_in = {in_root[WIDTH-2:0], take};
      rad_in  = {in_rad[2*WIDTH-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule : ggm_root_cell

`default_nettype wire

// ===== sv/godunov_gradient_magnitude.sv =====
// Top level of the Godunov upwind gradient magnitude block: front end,
// a chain of square-root cells and the output register with a skid entry.
// Depends on ggm_pkg, ggm_front and ggm_root_cell.
//
//   Channel   Direction   Handshake           Payload
//   req       in          req_valid/stall     level sign, four differences
//   rsp       out         rsp_valid/stall     gradient magnitude
//
// One request is taken per clock while req_stall is low. An accepted request
// passes three front stages, one root cell per result bit and one output
// stage, where it waits to be taken; the root-cell chain is the longest part.
// Synchronous reset clears every valid bit; payload registers are not reset.
// A stalled output parks one result in a skid entry, and req_stall is the
// registered skid flag, so the whole pipeline holds only while it is full.
`default_nettype none

module godunov_gradient_magnitude #(
   parameter int DIFF_WIDTH = ggm_pkg::DIFF_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [1:0]            req_level_sign,
   input  wire logic signed [DIFF_WIDTH-1:0] req_diff_x_back,
   input  wire logic signed [DIFF_WIDTH-1:0] req_diff_x_fwd,
   input  wire logic signed [DIFF_WIDTH-1:0] req_diff_y_back,
   input  wire logic signed [DIFF_WIDTH-1:0] req_diff_y_fwd,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [DIFF_WIDTH-1:0]             rsp_grad_magnitude
);

   localparam int W = DIFF_WIDTH;

   logic                 pipe_enable;
   logic                 req_take;
   logic                 front_valid;
   logic [2*W-1:0]       front_sum;

   logic                 cell_valid [0:W];
   logic [2*W-1:0]       cell_rad   [0:W];
   logic [W-1:0]         cell_rem   [0:W];
   logic [W-1:0]         cell_root  [0:W];

   logic                 out_take;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [W-1:0]         out_data_ff;
   logic [W-1:0]         out_data_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   logic [W-1:0]         skid_data_ff;
   logic [W-1:0]         skid_data_in;

   // The pipeline moves whenever the skid entry is free.
   assign pipe_enable = !skid_valid_ff;
   assign req_stall   = skid_valid_ff;
   assign req_take    = req_valid && pipe_enable;

   // Upwind selection, squares, axis maxima and sum.
   ggm_front #(
      .DIFF_WIDTH (W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .enable      (pipe_enable),
      .in_valid    (req_take),
      .level_sign  (req_level_sign),
      .diff_x_back (req_diff_x_back),
      .diff_x_fwd  (req_diff_x_fwd),
      .diff_y_back (req_diff_y_back),
      .diff_y_fwd  (req_diff_y_fwd),
      .out_valid   (front_valid),
      .out_sum     (front_sum)
   );

   // The sum enters the root chain with an empty remainder and root.
   assign cell_valid[0] = front_valid;
   assign cell_rad[0]   = front_sum;
   assign cell_rem[0]   = '0;
   assign cell_root[0]  = '0;

   // One root cell per result bit, most significant bit first.
   for (genvar i = 0; i < W; i++) begin : g_root
      ggm_root_cell #(
         .WIDTH (W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_enable),
         .in_valid  (cell_valid[i]),
         .in_rad    (cell_rad[i]),
         .in_rem    (cell_rem[i]),
         .in_root   (cell_root[i]),
         .out_valid (cell_valid[i+1]),
         .out_rad   (cell_rad[i+1]),
         .out_rem   (cell_rem[i+1]),
         .out_root  (cell_root[i+1])
      );
   end

   // Output register with one skid entry behind it.
   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in = cell_valid[W];
         out_data_in  = cell_root[W];
      end else if (cell_valid[W]) begin
         skid_valid_in = 1'b1;
         skid_data_in  = cell_root[W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_grad_magnitude = out_data_ff;

`ifndef SYNTH
   // The skid entry only fills behind a waiting output register.
   a_skid_behind_out : assert property (
      @(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff
   ) else $error("skid entry valid while output register empty");

   // A held pipeline must not lose or create its last result.
   a_hold_keeps_last : assert property (
      @(posedge clock) disable iff (reset)
      !pipe_enable |=> $stable(cell_valid[W])
   ) else $error("last root cell changed while pipeline held");

   // A result arriving at a stalled full output goes to the skid entry.
   a_skid_catches : assert property (
      @(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && pipe_enable && cell_valid[W]) |=> skid_valid_ff
   ) else $error("result arriving at stalled output was dropped");
`endif

endmodule : godunov_gradient_magnitude

`default_nettype wire

// ===== sim/tb_godunov_gradient_magnitude.sv =====
// Testbench for godunov_gradient_magnitude: directed and random grid points are checked
// against an in-bench upwind gradient predictor, random sender gaps and result stalls.
// Depends on ggm_pkg and the godunov_gradient_magnitude RTL.
`timescale 1ns / 100ps

module tb_godunov_gradient_magnitude;

   localparam int DW           = ggm_pkg::DIFF_WIDTH_DEFAULT;
   localparam int HALF_PERIOD  = 5;
   localparam int RANDOM_ITEMS = 1150;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;

   localparam logic signed [DW-1:0] MAX_DIFF = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MIN_DIFF = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] ONE_DIFF = {{(DW-1){1'b0}}, 1'b1};

   // Handshake pressure phases of the run.
   typedef enum int {
      PHASE_RSP_SLOW,
      PHASE_REQ_SLOW,
      PHASE_FREE
   } idle_phase_type;

   // One grid point waiting to be offered, with its pacing controls.
   typedef struct {
      logic [1:0]            sign_code;
      logic signed [DW-1:0]  x_back;
      logic signed [DW-1:0]  x_fwd;
      logic signed [DW-1:0]  y_back;
      logic signed [DW-1:0]  y_fwd;
      bit                    drain_first;
      bit                    hold_rsp;
      idle_phase_type        phase;
   } grid_point_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [1:0]    req_level_sign = '0;
   logic signed [DW-1:0] req_diff_x_back = '0;
   logic signed [DW-1:0] req_diff_x_fwd = '0;
   logic signed [DW-1:0] req_diff_y_back = '0;
   logic signed [DW-1:0] req_diff_y_fwd = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DW-1:0]        rsp_grad_magnitude;

   grid_point_type pending_points[$];
   logic [DW-1:0]  expected_magnitudes[$];

   logic           req_taken = 1'b0;
   logic           hold_req = 1'b0;
   idle_phase_type phase = PHASE_RSP_SLOW;
   int             hold_left = 0;
   int             idle_cycles = 0;
   int             mismatches = 0;
   int             results_checked = 0;
   int             zero_requests = 0;
   int             pos_requests = 0;
   int             neg_requests = 0;
   int             holds_done = 0;
   int             drains_done = 0;

   godunov_gradient_magnitude #(
      .DIFF_WIDTH(DW)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_level_sign     (req_level_sign),
      .req_diff_x_back    (req_diff_x_back),
      .req_diff_x_fwd     (req_diff_x_fwd),
      .req_diff_y_back    (req_diff_y_back),
      .req_diff_y_fwd     (req_diff_y_fwd),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_grad_magnitude (rsp_grad_magnitude)
   );

   always #HALF_PERIOD clock = ~clock;

   // Squares of the positive and negative parts of one difference.
   function automatic longint unsigned square_above(logic signed [DW-1:0] v);
      longint wide;
      wide = v;
      return (wide > 0) ? longint'(wide * wide) : 0;
   endfunction

   function automatic longint unsigned square_below(logic signed [DW-1:0] v);
      longint wide;
      wide = v;
      return (wide < 0) ? longint'(wide * wide) : 0;
   endfunction

   // Upwind gradient magnitude: per-axis larger upwind square, summed, floor root.
   function automatic logic [DW-1:0] upwind_magnitude(
      logic [1:0] sign_code,
      logic signed [DW-1:0] xb, logic signed [DW-1:0] xf,
      logic signed [DW-1:0] yb, logic signed [DW-1:0] yf
   );
      longint unsigned ax, ay, total, root, trial, lo, hi;
      root = 0;
      case (ggm_pkg::level_sign_type'(sign_code))
         ggm_pkg::SIGN_ZERO: return '0;
         ggm_pkg::SIGN_POS: begin
            lo = square_below(xb); hi = square_above(xf);
            ax = (lo >= hi) ? lo : hi;
            lo = square_below(yb); hi = square_above(yf);
            ay = (lo >= hi) ? lo : hi;
         end
         default: begin
            lo = square_above(xb); hi = square_below(xf);
            ax = (lo >= hi) ? lo : hi;
            lo = square_above(yb); hi = square_below(yf);
            ay = (lo >= hi) ? lo : hi;
         end
      endcase
      total = ax + ay;
      // Build the root one bit at a time from the top.
      for (int b = DW - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= total) root = trial;
      end
      return root[DW-1:0];
   endfunction

   function automatic int sender_idle_pct(idle_phase_type p);
      case (p)
         PHASE_RSP_SLOW: return 10;
         PHASE_REQ_SLOW: return 65;
         default:        return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct(idle_phase_type p);
      case (p)
         PHASE_RSP_SLOW: return 65;
         PHASE_REQ_SLOW: return 10;
         default:        return 0;
      endcase
   endfunction

   // A random difference drawn from a mix of full-range, small and corner values.
   function automatic logic signed [DW-1:0] random_diff();
      logic signed [DW-1:0] v;
      case ($urandom_range(5))
         1: v = DW'(int'($urandom_range(8191)) - 4096);
         2: begin
            case ($urandom_range(4))
               0: v = MAX_DIFF;
               1: v = MIN_DIFF;
               2: v = '0;
               3: v = ONE_DIFF;
               default: v = '1;
            endcase
         end
         3: v = DW'(int'($urandom_range(65535)) - 32768);
         default: v = DW'($urandom());
      endcase
      return v;
   endfunction

   function automatic logic [1:0] random_sign();
      case ($urandom_range(7))
         0:       return ggm_pkg::SIGN_ZERO;
         1, 2, 3: return ggm_pkg::SIGN_POS;
         4:       return ggm_pkg::SIGN_NEG_TWO;
         default: return ggm_pkg::SIGN_NEG;
      endcase
   endfunction

   task automatic add_point(logic [1:0] s, logic signed [DW-1:0] xb, logic signed [DW-1:0] xf,
                            logic signed [DW-1:0] yb, logic signed [DW-1:0] yf,
                            bit drain, bit hold, idle_phase_type p);
      grid_point_type pt;
      pt.sign_code = s;
      pt.x_back = xb;
      pt.x_fwd = xf;
      pt.y_back = yb;
      pt.y_fwd = yf;
      pt.drain_first = drain;
      pt.hold_rsp = hold;
      pt.phase = p;
      pending_points.push_back(pt);
   endtask

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Request driver: holds a stalled request, otherwise offers the next point.
   always @(negedge clock) begin : request_driver
      grid_point_type pt;
      logic           launch;
      launch = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         hold_req <= 1'b0;
      end else if (req_valid && !req_taken) begin
         hold_req <= 1'b0;
      end else begin
         if (pending_points.size() > 0
             && !(pending_points[0].drain_first && expected_magnitudes.size() > 0)
             && $urandom_range(99) >= sender_idle_pct(pending_points[0].phase))
            launch = 1'b1;
         if (launch) begin
            pt = pending_points.pop_front();
            if (pt.drain_first) drains_done++;
            req_level_sign <= pt.sign_code;
            req_diff_x_back <= pt.x_back;
            req_diff_x_fwd <= pt.x_fwd;
            req_diff_y_back <= pt.y_back;
            req_diff_y_fwd <= pt.y_fwd;
            phase <= pt.phase;
         end
         req_valid <= launch;
         hold_req <= launch && pt.hold_rsp;
      end
   end

   // Result receiver: random stalls per phase, plus a long hold-off on request.
   always @(negedge clock) begin : result_receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         holds_done++;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct(phase));
      end
   end

   // Monitor: predicts on each accepted request, checks each accepted result.
   always @(posedge clock) begin : channel_monitor
      logic [DW-1:0] want;
      logic          req_fire;
      logic          rsp_fire;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      req_taken <= req_fire;
      if (req_fire) begin
         expected_magnitudes.push_back(upwind_magnitude(req_level_sign, req_diff_x_back,
                                       req_diff_x_fwd, req_diff_y_back, req_diff_y_fwd));
         case (ggm_pkg::level_sign_type'(req_level_sign))
            ggm_pkg::SIGN_ZERO: zero_requests++;
            ggm_pkg::SIGN_POS:  pos_requests++;
            default:            neg_requests++;
         endcase
      end
      if (rsp_fire) begin
         if (expected_magnitudes.size() == 0) begin
            report_mismatch($sformatf("result %0d with no request waiting",
                                      rsp_grad_magnitude));
         end else begin
            want = expected_magnitudes.pop_front();
            results_checked++;
            if (rsp_grad_magnitude !== want)
               report_mismatch($sformatf("grad_magnitude got %0d expected %0d",
                                         rsp_grad_magnitude, want));
         end
      end
      // Watchdog on cycles with no traffic on either channel.
      if (req_fire || rsp_fire) idle_cycles = 0;
      else if (!reset) idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus
      logic [1:0]     signs[3];
      idle_phase_type p;
      signs = '{ggm_pkg::SIGN_POS, ggm_pkg::SIGN_NEG, ggm_pkg::SIGN_NEG_TWO};

      // Directed points: corners of the differences for each nonzero sign.
      foreach (signs[k]) begin
         add_point(signs[k], MAX_DIFF, MAX_DIFF, MAX_DIFF, MAX_DIFF, 0, 0, PHASE_RSP_SLOW);
         add_point(signs[k], MIN_DIFF, MIN_DIFF, MIN_DIFF, MIN_DIFF, 0, 0, PHASE_RSP_SLOW);
         add_point(signs[k], '0, '0, '0, '0, 0, 0, PHASE_RSP_SLOW);
         add_point(signs[k], MIN_DIFF, MAX_DIFF, MIN_DIFF, MAX_DIFF, 0, 0, PHASE_RSP_SLOW);
         add_point(signs[k], MAX_DIFF, MIN_DIFF, MAX_DIFF, MIN_DIFF, 0, 0, PHASE_RSP_SLOW);
         add_point(signs[k], '1, ONE_DIFF, ONE_DIFF, '1, 0, 0, PHASE_RSP_SLOW);
      end
      // A zero sign gives zero whatever the differences are.
      add_point(ggm_pkg::SIGN_ZERO, MAX_DIFF, MAX_DIFF, MAX_DIFF, MAX_DIFF, 0, 0,
                PHASE_RSP_SLOW);
      add_point(ggm_pkg::SIGN_ZERO, MIN_DIFF, MIN_DIFF, MIN_DIFF, MIN_DIFF, 0, 0,
                PHASE_RSP_SLOW);

      // Random points in three pacing phases, with hold-offs and drain pauses.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < RANDOM_ITEMS / 3) p = PHASE_RSP_SLOW;
         else if (i < 2 * RANDOM_ITEMS / 3) p = PHASE_REQ_SLOW;
         else p = PHASE_FREE;
         add_point(random_sign(), random_diff(), random_diff(), random_diff(), random_diff(),
                   (i == RANDOM_ITEMS / 3) || (i == 2 * RANDOM_ITEMS / 3) || (i == 1000),
                   (i == 150) || (i == 900), p);
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Wait for all stimulus to be taken and every result to come back.
      do begin
         @(negedge clock);
         #1;
      end while (pending_points.size() != 0 || req_valid || expected_magnitudes.size() != 0);
      repeat (DW + 8) @(negedge clock);

      if (expected_magnitudes.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_magnitudes.size()));
      $display("Covered %0d results: %0d zero-sign, %0d positive, %0d negative requests.",
               results_checked, zero_requests, pos_requests, neg_requests);
      $display("Receiver hold-offs: %0d, sender drain pauses: %0d, mismatches: %0d.",
               holds_done, drains_done, mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule : tb_godunov_gradient_magnitude

// ===== files.f =====
sv/ggm_pkg.sv
sv/ggm_front.sv
sv/ggm_root_cell.sv
sv/godunov_gradient_magnitude.sv
sim/tb_godunov_gradient_magnitude.sv
